>>> hdl/swlms_pkg.sv
// Shared types and constants for the stopwatch LED matrix scanner.
// Holds the glyph font table and the queue item format; no dependencies.
package swlms_pkg;

   localparam int ROWS        = 16;
   localparam int ROW_W       = 4;
   localparam int GLYPH_W     = 4;
   localparam int DIGITS      = 6;
   localparam int TPS_W       = 16;
   localparam int TICK_W      = 16;
   localparam int SEC_W       = 6;
   localparam int MIN_W       = 6;
   localparam int HOUR_W      = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QCOUNT_W    = 2;

   localparam logic [TPS_W-1:0]   TPS_RESET  = 16'd1000;
   localparam logic [SEC_W-1:0]   SEC_LIMIT  = 6'd60;
   localparam logic [MIN_W-1:0]   MIN_LIMIT  = 6'd60;
   localparam logic [HOUR_W-1:0]  HOUR_LIMIT = 7'd99;
   localparam logic [GLYPH_W-1:0] GLYPH_DASH = 4'd10;

   // one display row request: row number plus the six time digits
   // (hour tens, hour ones, minute tens, minute ones, second tens, second ones)
   typedef struct packed {
      logic [ROW_W-1:0]                 row;
      logic [DIGITS-1:0][GLYPH_W-1:0]   digit;
   } entry_type;

   localparam logic [7:0] FONT_ROM [0:10][0:15] = '{
      '{8'h00,8'h00,8'h00,8'h18,8'h24,8'h42,8'h42,8'h42,
        8'h42,8'h42,8'h42,8'h42,8'h24,8'h18,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h10,8'h70,8'h10,8'h10,8'h10,
        8'h10,8'h10,8'h10,8'h10,8'h10,8'h7C,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h3C,8'h42,8'h42,8'h42,8'h04,
        8'h04,8'h08,8'h10,8'h20,8'h42,8'h7E,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h3C,8'h42,8'h42,8'h04,8'h18,
        8'h04,8'h02,8'h02,8'h42,8'h44,8'h38,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h04,8'h0C,8'h14,8'h24,8'h24,
        8'h44,8'h44,8'h7E,8'h04,8'h04,8'h1E,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h7E,8'h40,8'h40,8'h40,8'h58,
        8'h64,8'h02,8'h02,8'h42,8'h44,8'h38,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h1C,8'h24,8'h40,8'h40,8'h58,
        8'h64,8'h42,8'h42,8'h42,8'h24,8'h18,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h7E,8'h44,8'h44,8'h08,8'h08,
        8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h3C,8'h42,8'h42,8'h42,8'h24,
        8'h18,8'h24,8'h42,8'h42,8'h42,8'h3C,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h18,8'h24,8'h42,8'h42,8'h42,
        8'h26,8'h1A,8'h02,8'h02,8'h24,8'h38,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h7E,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
   };

   // anything past the dash code shows as a dash
   function automatic logic [7:0] font_row(input logic [GLYPH_W-1:0] glyph,
                                           input logic [ROW_W-1:0]   row);
      logic [GLYPH_W-1:0] g;
      begin
         g = (glyph > GLYPH_DASH) ? GLYPH_DASH : glyph;
         return FONT_ROM[g][row];
      end
   endfunction

endpackage

>>> hdl/swlms_front.sv
// Front end: accepts tick items, keeps the stopwatch counters and scan row,
// and pushes the row number and time digits into the queue. Uses swlms_pkg.
module swlms_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_run,
   input  logic                          csr_write_enable,
   input  logic [swlms_pkg::TPS_W-1:0]   csr_write_data,
   input  logic                          q_full,
   output logic                          q_push,
   output swlms_pkg::entry_type          q_entry
);

   logic [swlms_pkg::TPS_W-1:0]  tps_ff;
   logic [swlms_pkg::TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [swlms_pkg::SEC_W-1:0]  seconds_ff, seconds_in;
   logic [swlms_pkg::MIN_W-1:0]  minutes_ff, minutes_in;
   logic [swlms_pkg::HOUR_W-1:0] hours_ff, hours_in;
   logic [swlms_pkg::ROW_W-1:0]  scan_row_ff;

   logic [swlms_pkg::TICK_W:0]   next_cnt;
   logic                         sec_carry;
   logic [swlms_pkg::SEC_W-1:0]  sec_tmp;
   logic [swlms_pkg::MIN_W-1:0]  min_tmp;
   logic [swlms_pkg::HOUR_W-1:0] hour_tmp;
   logic                         accept;

   // tens digit of a value below 100, by threshold compares
   function automatic logic [swlms_pkg::GLYPH_W-1:0] tens_of(input logic [6:0] v);
      logic [swlms_pkg::GLYPH_W-1:0] t;
      begin
         t = '0;
         for (int k = 1; k < 10; k++) begin
            if (v >= 7'(10 * k)) t = swlms_pkg::GLYPH_W'(k);
         end
         return t;
      end
   endfunction

   function automatic logic [swlms_pkg::GLYPH_W-1:0] ones_of(input logic [6:0] v);
      logic [6:0] rem;
      begin
         rem = v - 7'(tens_of(v)) * 7'd10;
         return rem[swlms_pkg::GLYPH_W-1:0];
      end
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   always_comb begin
      next_cnt      = {1'b0, tick_count_ff} + 17'd1;
      sec_carry     = next_cnt >= {1'b0, tps_ff};
      tick_count_in = tick_count_ff;
      seconds_in    = '0;
      minutes_in    = '0;
      hours_in      = '0;
      sec_tmp       = seconds_ff + swlms_pkg::SEC_W'(sec_carry);
      min_tmp       = minutes_ff;
      hour_tmp      = hours_ff;
      if (req_run) begin
         tick_count_in = sec_carry ? '0 : next_cnt[swlms_pkg::TICK_W-1:0];
         if (sec_tmp >= swlms_pkg::SEC_LIMIT) begin
            sec_tmp = '0;
            min_tmp = minutes_ff + 6'd1;
         end
         if (min_tmp >= swlms_pkg::MIN_LIMIT) begin
            min_tmp  = '0;
            hour_tmp = hours_ff + 7'd1;
         end
         if (hour_tmp >= swlms_pkg::HOUR_LIMIT) hour_tmp = '0;
         seconds_in = sec_tmp;
         minutes_in = min_tmp;
         hours_in   = hour_tmp;
      end
      q_entry.row      = scan_row_ff;
      q_entry.digit[5] = tens_of(hours_in);
      q_entry.digit[4] = ones_of(hours_in);
      q_entry.digit[3] = tens_of({1'b0, minutes_in});
      q_entry.digit[2] = ones_of({1'b0, minutes_in});
      q_entry.digit[1] = tens_of({1'b0, seconds_in});
      q_entry.digit[0] = ones_of({1'b0, seconds_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff        <= swlms_pkg::TPS_RESET;
         tick_count_ff <= '0;
         seconds_ff    <= '0;
         minutes_ff    <= '0;
         hours_ff      <= '0;
         scan_row_ff   <= '0;
      end else begin
         if (csr_write_enable) tps_ff <= csr_write_data;
         if (accept) begin
            tick_count_ff <= tick_count_in;
            seconds_ff    <= seconds_in;
            minutes_ff    <= minutes_in;
            hours_ff      <= hours_in;
            scan_row_ff   <= scan_row_ff + 4'd1;
         end
      end
   end

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_run) |=> (seconds_ff == '0 && minutes_ff == '0 && hours_ff == '0))
      else $error("stopped item did not clear the time");

   a_row_advances: assert property (@(posedge clock) disable iff (reset)
      accept |=> (scan_row_ff == $past(scan_row_ff) + 4'd1))
      else $error("scan row did not advance on an item");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (seconds_ff < swlms_pkg::SEC_LIMIT && minutes_ff < swlms_pkg::MIN_LIMIT
       && hours_ff < swlms_pkg::HOUR_LIMIT))
      else $error("time counter out of range");

endmodule

>>> hdl/swlms_queue.sv
// Two-entry queue between the counting front end and the row builder.
// Uses swlms_pkg for the entry format and depth.
module swlms_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  swlms_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output swlms_pkg::entry_type pop_entry
);

   swlms_pkg::entry_type                mem_ff [swlms_pkg::QUEUE_DEPTH];
   logic                                wr_ptr_ff;
   logic                                rd_ptr_ff;
   logic [swlms_pkg::QCOUNT_W-1:0]      count_ff, count_in;

   assign full      = count_ff == swlms_pkg::QCOUNT_W'(swlms_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

>>> hdl/swlms_back.sv
// Back end: takes queue entries, looks up the glyph rows in the font table
// and holds the inverted 64-bit row in the output register. Uses swlms_pkg.
module swlms_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   input  swlms_pkg::entry_type          q_entry,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swlms_pkg::ROW_W-1:0]   rsp_row_index,
   output logic [63:0]                   rsp_row_bits
);

   logic                         rsp_valid_ff;
   logic [swlms_pkg::ROW_W-1:0]  row_index_ff;
   logic [63:0]                  row_bits_ff, row_bits_in;
   logic [7:0][swlms_pkg::GLYPH_W-1:0] glyph;

   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      glyph[7] = q_entry.digit[5];
      glyph[6] = q_entry.digit[4];
      glyph[5] = swlms_pkg::GLYPH_DASH;
      glyph[4] = q_entry.digit[3];
      glyph[3] = q_entry.digit[2];
      glyph[2] = swlms_pkg::GLYPH_DASH;
      glyph[1] = q_entry.digit[1];
      glyph[0] = q_entry.digit[0];
      for (int k = 0; k < 8; k++) begin
         row_bits_in[k*8 +: 8] = ~swlms_pkg::font_row(glyph[k], q_entry.row);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         row_index_ff <= q_entry.row;
         row_bits_ff  <= row_bits_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = row_index_ff;
   assign rsp_row_bits  = row_bits_ff;

   a_row_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && q_pop) |=> (row_index_ff == $past(row_index_ff) + 4'd1))
      else $error("output rows out of order");

   a_dash_columns: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (row_bits_ff[47:40] == row_bits_ff[23:16]))
      else $error("dash columns differ");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff)
      else $error("popped item not shown");

endmodule

>>> hdl/stopwatch_led_matrix_scanner.sv
// Top level of the stopwatch LED matrix scanner: front end, queue, row builder.
// Depends on swlms_pkg, swlms_front, swlms_queue and swlms_back.
//
//   channel  ports                               direction  handshake
//   req      req_valid req_ready req_run          in         valid/ready
//   rsp      rsp_valid rsp_ready rsp_row_index    out        valid/ready
//            rsp_row_bits
//   csr      csr_write_enable csr_write_data      in         write enable, no wait
//
// One item per clock sustained while rsp_ready stays high; an accepted item's row is
// written into the queue at the accepting edge, together with the front end update,
// and its font lookup is registered into the output register when the row builder pops it.
// A two-entry queue separates the counters from the output register, so req_ready
// drops only when both entries are held behind a stalled rsp channel.
// Synchronous active-high reset clears counters, queue and output valid;
// ticks_per_second resets to 1000.
module stopwatch_led_matrix_scanner (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_run,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swlms_pkg::ROW_W-1:0]   rsp_row_index,
   output logic [63:0]                   rsp_row_bits,
   input  logic                          csr_write_enable,
   input  logic [swlms_pkg::TPS_W-1:0]   csr_write_data
);

   logic                 q_full;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_not_empty;
   swlms_pkg::entry_type push_entry;
   swlms_pkg::entry_type pop_entry;

   swlms_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_run          (req_run),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   swlms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_entry  (pop_entry)
   );

   swlms_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_entry       (pop_entry),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_row_bits  (rsp_row_bits)
   );

endmodule
